>>> rtl/core/bdq_pkg.sv
// Shared constants, codes and cell control types of the bounded deque.
package bdq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_DUMP       = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_POPPED   = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_FULL     = 3'd3,
		ST_DUMPED   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH_FRONT,
		CELL_PUSH_BACK,
		CELL_SHIFT,
		CELL_ROTATE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic      at_tail;
		logic      at_count;
	} cell_ctl_t;

endpackage

>>> rtl/core/bounded_deque_push_pop_dump.sv
// Top level of the bounded deque: command decode, fill count and the chain of cells.
// A command is taken on a clock edge where start is high and busy is low; op selects
// push front, push back, pop front or dump, and value carries the word to push.
// Every command gives its results on status, data_out and last, each valid for
// exactly one cycle while strobe is high; the receiver cannot stall the block.
// The first result appears in the cycle after the command is taken.
// Push and pop never raise busy, so a new command can be given in every cycle while busy is low.
// A dump of N stored words gives N results, one per cycle, front to back,
// with last high on the final one; busy stays high from the first result until the
// final one, while the cell chain rotates its words one place per cycle and returns to
// its original order. A dump of an empty store gives one empty result.
// A push into a full store is dropped with a full result, and a pop of an empty
// store gives an empty result; both leave the contents unchanged.
// Words are held in a row of cells with the front word in the first cell; a push
// front or a pop shifts the whole row by one place.
// Reset clears the fill count, the dump sequencer and the strobe; stored words
// are not cleared and are only ever read after having been written.
module bounded_deque_push_pop_dump (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       op,
	input  logic signed [bdq_pkg::DATA_W-1:0] value,
	output logic                             strobe,
	output logic [2:0]                       status,
	output logic signed [bdq_pkg::DATA_W-1:0] data_out,
	output logic                             last
);

	logic [bdq_pkg::CNT_W-1:0]         count_q;
	logic [bdq_pkg::CNT_W-1:0]         remain_q;
	logic                              dumping_q;
	logic                              strobe_q;
	bdq_pkg::status_t                  status_q;
	logic signed [bdq_pkg::DATA_W-1:0] data_out_q;
	logic                              last_q;

	logic                              accept;
	logic                              full;
	logic                              empty;
	bdq_pkg::op_t                      op_in;
	bdq_pkg::cell_cmd_t                cmd;
	logic signed [bdq_pkg::DATA_W-1:0] cell_data [bdq_pkg::DEPTH];

	assign accept = start && !dumping_q;
	assign full = (count_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
	assign empty = (count_q == '0);
	assign op_in = bdq_pkg::op_t'(op);

	always_comb begin
		cmd = bdq_pkg::CELL_HOLD;
		if (dumping_q) begin
			cmd = bdq_pkg::CELL_ROTATE;
		end else if (accept) begin
			case (op_in)
				bdq_pkg::OP_PUSH_FRONT: begin
					if (!full) cmd = bdq_pkg::CELL_PUSH_FRONT;
				end
				bdq_pkg::OP_PUSH_BACK: begin
					if (!full) cmd = bdq_pkg::CELL_PUSH_BACK;
				end
				bdq_pkg::OP_POP_FRONT: begin
					if (!empty) cmd = bdq_pkg::CELL_SHIFT;
				end
				bdq_pkg::OP_DUMP: begin
					if (!empty) cmd = bdq_pkg::CELL_ROTATE;
				end
				default: begin
					cmd = bdq_pkg::CELL_HOLD;
				end
			endcase
		end
	end

	for (genvar i = 0; i < bdq_pkg::DEPTH; i++) begin : g_cell
		bdq_pkg::cell_ctl_t                ctl;
		logic signed [bdq_pkg::DATA_W-1:0] left_data;
		logic signed [bdq_pkg::DATA_W-1:0] right_data;

		assign ctl.cmd = cmd;
		assign ctl.at_tail = (count_q == bdq_pkg::CNT_W'(i + 1));
		assign ctl.at_count = (count_q == bdq_pkg::CNT_W'(i));

		if (i == 0) begin : g_first
			assign left_data = value;
		end else begin : g_inner_left
			assign left_data = cell_data[i-1];
		end

		if (i == bdq_pkg::DEPTH - 1) begin : g_end
			assign right_data = '0;
		end else begin : g_inner_right
			assign right_data = cell_data[i+1];
		end

		bdq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.left_data  (left_data),
			.right_data (right_data),
			.front_data (cell_data[0]),
			.value      (value),
			.data       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			remain_q   <= '0;
			dumping_q  <= 1'b0;
			strobe_q   <= 1'b0;
			status_q   <= bdq_pkg::ST_INSERTED;
			data_out_q <= '0;
			last_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (dumping_q) begin
				strobe_q   <= 1'b1;
				status_q   <= bdq_pkg::ST_DUMPED;
				data_out_q <= cell_data[0];
				last_q     <= (remain_q == bdq_pkg::CNT_W'(1));
				remain_q   <= remain_q - bdq_pkg::CNT_W'(1);
				if (remain_q == bdq_pkg::CNT_W'(1)) begin
					dumping_q <= 1'b0;
				end
			end else if (accept) begin
				strobe_q   <= 1'b1;
				last_q     <= 1'b1;
				data_out_q <= '0;
				case (op_in)
					bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
						if (full) begin
							status_q <= bdq_pkg::ST_FULL;
						end else begin
							status_q <= bdq_pkg::ST_INSERTED;
							count_q  <= count_q + bdq_pkg::CNT_W'(1);
						end
					end
					bdq_pkg::OP_POP_FRONT: begin
						if (empty) begin
							status_q <= bdq_pkg::ST_EMPTY;
						end else begin
							status_q   <= bdq_pkg::ST_POPPED;
							data_out_q <= cell_data[0];
							count_q    <= count_q - bdq_pkg::CNT_W'(1);
						end
					end
					bdq_pkg::OP_DUMP: begin
						if (empty) begin
							status_q <= bdq_pkg::ST_EMPTY;
						end else begin
							status_q   <= bdq_pkg::ST_DUMPED;
							data_out_q <= cell_data[0];
							last_q     <= (count_q == bdq_pkg::CNT_W'(1));
							remain_q   <= count_q - bdq_pkg::CNT_W'(1);
							dumping_q  <= (count_q != bdq_pkg::CNT_W'(1));
						end
					end
					default: begin
						status_q <= bdq_pkg::ST_EMPTY;
					end
				endcase
			end
		end
	end

	assign busy = dumping_q;
	assign strobe = strobe_q;
	assign status = status_q;
	assign data_out = data_out_q;
	assign last = last_q;

endmodule

>>> rtl/core/bdq_cell.sv
// One storage cell of the deque chain, moving its word toward either neighbor.
module bdq_cell (
	input  logic                             clk,
	input  bdq_pkg::cell_ctl_t               ctl,
	input  logic signed [bdq_pkg::DATA_W-1:0] left_data,
	input  logic signed [bdq_pkg::DATA_W-1:0] right_data,
	input  logic signed [bdq_pkg::DATA_W-1:0] front_data,
	input  logic signed [bdq_pkg::DATA_W-1:0] value,
	output logic signed [bdq_pkg::DATA_W-1:0] data
);

	logic signed [bdq_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			bdq_pkg::CELL_PUSH_FRONT: begin
				data_q <= left_data;
			end
			bdq_pkg::CELL_PUSH_BACK: begin
				if (ctl.at_count) begin
					data_q <= value;
				end
			end
			bdq_pkg::CELL_SHIFT: begin
				data_q <= right_data;
			end
			bdq_pkg::CELL_ROTATE: begin
				data_q <= ctl.at_tail ? front_data : right_data;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

>>> tb/sv/bounded_deque_push_pop_dump_test.sv
// Self-checking testbench for the bounded deque: directed and random commands against a predictor.
module bounded_deque_push_pop_dump_test;
	import bdq_pkg::*;

	typedef struct {
		op_t                      cmd;
		logic signed [DATA_W-1:0] word;
	} deque_command_t;

	typedef struct {
		status_t                  status;
		logic signed [DATA_W-1:0] data;
		logic                     last;
	} deque_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               op = OP_PUSH_FRONT;
	logic signed [DATA_W-1:0] value = '0;
	logic                     strobe;
	logic [2:0]               status;
	logic signed [DATA_W-1:0] data_out;
	logic                     last;

	deque_command_t pending_commands[$];
	deque_result_t  expected_results[$];

	logic [DATA_W-1:0] model_ring[DEPTH];
	int                model_head = 0;
	int                model_fill = 0;

	int burst_left = 4;
	int gap_left = 0;
	int commands_applied = 0;
	int results_checked = 0;
	int full_drops = 0;
	int empty_reports = 0;
	int dumped_words = 0;
	int mismatches = 0;

	bounded_deque_push_pop_dump i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.value    (value),
		.strobe   (strobe),
		.status   (status),
		.data_out (data_out),
		.last     (last)
	);

	always #2 clk = ~clk;

	function automatic void expect_result(status_t s, logic [DATA_W-1:0] d, logic l);
		deque_result_t r;
		r.status = s;
		r.data = d;
		r.last = l;
		expected_results.push_back(r);
	endfunction

	function automatic void apply_deque_command(op_t cmd, logic [DATA_W-1:0] word);
		int i;
		case (cmd)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (model_fill >= DEPTH) begin
					expect_result(ST_FULL, '0, 1'b1);
				end else begin
					if (cmd == OP_PUSH_FRONT) begin
						model_head = (model_head + DEPTH - 1) % DEPTH;
						model_ring[model_head] = word;
					end else begin
						model_ring[(model_head + model_fill) % DEPTH] = word;
					end
					model_fill++;
					expect_result(ST_INSERTED, '0, 1'b1);
				end
			end
			OP_POP_FRONT: begin
				if (model_fill == 0) begin
					expect_result(ST_EMPTY, '0, 1'b1);
				end else begin
					expect_result(ST_POPPED, model_ring[model_head], 1'b1);
					model_head = (model_head + 1) % DEPTH;
					model_fill--;
				end
			end
			default: begin
				if (model_fill == 0) begin
					expect_result(ST_EMPTY, '0, 1'b1);
				end else begin
					for (i = 0; i < model_fill; i++) begin
						expect_result(ST_DUMPED, model_ring[(model_head + i) % DEPTH],
							i == model_fill - 1);
					end
				end
			end
		endcase
	endfunction

	function automatic void queue_command(op_t cmd, logic [DATA_W-1:0] word);
		deque_command_t c;
		c.cmd = cmd;
		c.word = word;
		pending_commands.push_back(c);
	endfunction

	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				apply_deque_command(op_t'(op), value);
				commands_applied++;
				void'(pending_commands.pop_front());
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_commands.size() > 0) begin
					op <= pending_commands[0].cmd;
					value <= pending_commands[0].word;
					start <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		deque_result_t exp_r;
		if (arst_n && strobe) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d data_out %0d last %0d",
					status, data_out, last);
				mismatches++;
			end else begin
				exp_r = expected_results.pop_front();
				case (exp_r.status)
					ST_FULL: full_drops++;
					ST_EMPTY: empty_reports++;
					ST_DUMPED: dumped_words++;
					default: ;
				endcase
				if (status !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, status);
					mismatches++;
				end
				if (data_out !== exp_r.data) begin
					$error("data_out: expected %0d, actual %0d", exp_r.data, data_out);
					mismatches++;
				end
				if (last !== exp_r.last) begin
					$error("last: expected %0d, actual %0d", exp_r.last, last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int n;
		int len;
		int push_bias;
		int r;

		// Directed: empty cases, extreme words, fill to full, full drops, full dump.
		queue_command(OP_POP_FRONT, 32'h1234_5678);
		queue_command(OP_DUMP, 32'hffff_ffff);
		queue_command(OP_PUSH_BACK, 32'h7fff_ffff);
		queue_command(OP_PUSH_FRONT, 32'h8000_0000);
		queue_command(OP_DUMP, '0);
		queue_command(OP_POP_FRONT, '0);
		for (int k = 0; k < DEPTH - 1; k++) begin
			case (k % 4)
				0: queue_command(OP_PUSH_FRONT, 32'hffff_ffff);
				1: queue_command(OP_PUSH_BACK, 32'h0000_0000);
				2: queue_command(OP_PUSH_FRONT, 32'h5555_5555);
				default: queue_command(OP_PUSH_BACK, 32'haaaa_aaaa);
			endcase
		end
		queue_command(OP_PUSH_FRONT, 32'h7fff_ffff);
		queue_command(OP_PUSH_BACK, 32'h8000_0000);
		queue_command(OP_DUMP, '0);
		queue_command(OP_POP_FRONT, '0);

		// Random: phases that lean toward filling or draining the store.
		n = 0;
		while (n < 125) begin
			push_bias = $urandom_range(0, 1) ? 80 : 25;
			len = $urandom_range(8, 30);
			for (int j = 0; j < len; j++) begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					queue_command(OP_DUMP, $urandom);
				end else if (r < 12 + push_bias * 88 / 100) begin
					queue_command($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
						random_word());
				end else begin
					queue_command(OP_POP_FRONT, $urandom);
				end
				n++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(negedge clk);
		end while (pending_commands.size() != 0 || start || expected_results.size() != 0);
		repeat (DEPTH + 4) @(negedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			mismatches++;
		end

		$display("Applied %0d commands and checked %0d results, including %0d dumped words,",
			commands_applied, results_checked, dumped_words);
		$display("%0d dropped pushes into a full store and %0d empty reports.",
			full_drops, empty_reports);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("Timeout waiting for results");
		$display("Mismatches found");
		$finish;
	end

endmodule
